>>> hw/rtl/sha256_stream_hasher_macros.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Plain check, sampled on clk and held off during reset.
`define SSH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sha256 stream hasher check failed");

// Check on the cycle after the condition.
`define SSH_ASSERT_NEXT(lbl, pre, post) \
	`SSH_ASSERT(lbl, (pre) |=> (post))

`endif

>>> hw/rtl/s256sh_pkg.sv
// Constants and round functions for the SHA-256 stream hasher.
`default_nettype none

package s256sh_pkg;

	localparam int unsigned ROUNDS     = 64;
	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned BLOCK_BITS = 512;
	localparam int unsigned LEN_POS    = 56;

	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher: byte absorb, padding sequencer and one-round-per-cycle compressor.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | sink      | in_valid / in_ready  | action, data_byte
//  out     | source    | out_valid / out_ready| digest_word, word_index, last_word
//
// An absorb item is taken only while idle; the one that completes a 64-byte block holds
// in_ready low through 64 rounds of the shared round unit and one hash update.
// A finish item shifts in (64 - pending bytes) padding bytes, one per cycle, then
// compresses; with more than 55 bytes pending it pads and compresses a second block.
// The digest sits in its own register, so the next message may start while the
// eight words drain; a finish waits only if the previous digest is still draining.
// Reset (arst_n low) restores the initial hash value and an empty message at once.
`default_nettype none

module sha256_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	`include "sha256_stream_hasher_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_DUMP
	} state_t;

	localparam logic [5:0] LAST_ROUND = 6'(s256sh_pkg::ROUNDS - 1);
	localparam logic [5:0] LAST_BYTE  = 6'(s256sh_pkg::BLOCK_BITS / 8 - 1);
	localparam logic [5:0] LEN_START  = 6'(s256sh_pkg::LEN_POS);

	state_t        state_q;
	logic [5:0]    rnd_q;
	logic [5:0]    fill_q;
	logic [63:0]   bit_cnt_q;
	logic          len_ok_q;
	logic          pad_first_q;
	logic          finishing_q;
	logic [31:0]   hash_q [s256sh_pkg::HASH_WORDS];
	logic          out_valid_q;
	logic [2:0]    out_idx_q;

	logic [511:0]  win_q;
	logic [31:0]   v_q [s256sh_pkg::HASH_WORDS];
	logic [31:0]   out_words_q [s256sh_pkg::HASH_WORDS];

	logic          in_acc;
	logic          out_acc;
	logic          len_sel;
	logic [7:0]    pad_byte;
	logic          absorb_fill;
	logic          pad_fill;
	logic          dump_go;
	logic [31:0]   w0, w1, w9, w14;
	logic [31:0]   new_w;
	logic [31:0]   t1, t2, ch, maj;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;

	assign out_valid   = out_valid_q;
	assign digest_word = out_words_q[0];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'(s256sh_pkg::HASH_WORDS - 1));

	// length bytes go in only on the block that closes the message
	assign len_sel  = len_ok_q && (fill_q >= LEN_START);
	assign pad_byte = pad_first_q ? s256sh_pkg::PAD_MARK
	                              : (len_sel ? bit_cnt_q[63:56] : 8'h00);

	assign absorb_fill = in_acc && !action && (fill_q == LAST_BYTE);
	assign pad_fill    = (state_q == ST_PAD) && (fill_q == LAST_BYTE);
	assign dump_go     = (state_q == ST_DUMP) && !out_valid_q;

	// message schedule taps of the 16-word window
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign new_w = s256sh_pkg::small_sigma1(w14) + w9 + s256sh_pkg::small_sigma0(w1) + w0;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + s256sh_pkg::big_sigma1(v_q[4]) + ch
	             + s256sh_pkg::ROUND_K[rnd_q] + w0;
	assign t2  = s256sh_pkg::big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			fill_q      <= '0;
			bit_cnt_q   <= '0;
			len_ok_q    <= 1'b0;
			pad_first_q <= 1'b0;
			finishing_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			for (int i = 0; i < s256sh_pkg::HASH_WORDS; i++) begin
				hash_q[i] <= s256sh_pkg::HASH_IV[i];
			end
		end else begin
			if (out_acc) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (last_word) begin
					out_valid_q <= 1'b0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!action) begin
							fill_q    <= fill_q + 6'd1;
							bit_cnt_q <= bit_cnt_q + s256sh_pkg::BYTE_BITS;
							if (fill_q == LAST_BYTE) begin
								rnd_q   <= '0;
								state_q <= ST_ROUND;
							end
						end else begin
							len_ok_q    <= (fill_q < LEN_START);
							pad_first_q <= 1'b1;
							finishing_q <= 1'b1;
							state_q     <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q      <= fill_q + 6'd1;
					pad_first_q <= 1'b0;
					if (!pad_first_q && len_sel) begin
						bit_cnt_q <= {bit_cnt_q[55:0], 8'h00};
					end
					if (fill_q == LAST_BYTE) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < s256sh_pkg::HASH_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					priority if (!finishing_q) begin
						state_q <= ST_IDLE;
					end else if (len_ok_q) begin
						state_q <= ST_DUMP;
					end else begin
						// extra block: zeros then the length
						len_ok_q <= 1'b1;
						state_q  <= ST_PAD;
					end
				end
				ST_DUMP: begin
					if (!out_valid_q) begin
						for (int i = 0; i < s256sh_pkg::HASH_WORDS; i++) begin
							hash_q[i] <= s256sh_pkg::HASH_IV[i];
						end
						bit_cnt_q   <= '0;
						fill_q      <= '0;
						len_ok_q    <= 1'b0;
						finishing_q <= 1'b0;
						out_valid_q <= 1'b1;
						out_idx_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: schedule window, working variables, digest output register
	always_ff @(posedge clk) begin
		if (in_acc && !action) begin
			win_q <= {win_q[503:0], data_byte};
		end else if (state_q == ST_PAD) begin
			win_q <= {win_q[503:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], new_w};
		end

		if (absorb_fill || pad_fill) begin
			for (int i = 0; i < s256sh_pkg::HASH_WORDS; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end

		if (dump_go) begin
			for (int i = 0; i < s256sh_pkg::HASH_WORDS; i++) begin
				out_words_q[i] <= hash_q[i];
			end
		end else if (out_acc) begin
			for (int i = 0; i < s256sh_pkg::HASH_WORDS - 1; i++) begin
				out_words_q[i] <= out_words_q[i + 1];
			end
		end
	end

	`SSH_ASSERT(a_first_word, $rose(out_valid) |-> (word_index == 3'd0))
	`SSH_ASSERT_NEXT(a_last_drops, out_valid && out_ready && last_word, !out_valid)
	`SSH_ASSERT_NEXT(a_round_end, (state_q == ST_ROUND) && (rnd_q == LAST_ROUND), state_q == ST_FINAL)
	`SSH_ASSERT_NEXT(a_block_start, absorb_fill, (state_q == ST_ROUND) && (rnd_q == 6'd0))

endmodule

`default_nettype wire
